// ===== hdl/overlap_alignment_quality_filter_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Overlap alignment quality filter: assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef OVERLAP_ALIGNMENT_QUALITY_FILTER_UNIT_DEFINES_SVH
`define OVERLAP_ALIGNMENT_QUALITY_FILTER_UNIT_DEFINES_SVH

// condition holds at every edge
`define OAQF_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define OAQF_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define OAQF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/oaqf_pkg.sv =====
// ---------------------------------------------------------------------------
// Overlap alignment quality filter package
// Widths, register indexes, configuration and pipeline payload types.
// ---------------------------------------------------------------------------
package oaqf_pkg;

   localparam int SITE_W     = 15;
   localparam int SCORE_W    = 16;
   localparam int GAIN_W     = 8;
   localparam int RATIO_W    = 16;
   localparam int ACC_W      = 32;
   localparam int SINGLE_W   = 10;
   localparam int GAP_W      = 26;
   localparam int DIFF_W     = SITE_W + 1;
   localparam int GSUM_W     = DIFF_W + 2;
   localparam int STEP_W     = GSUM_W + GAIN_W + 1;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;
   localparam int PCT_W      = 7;
   localparam int LHS_W      = SINGLE_W + PCT_W;
   localparam int RHS_W      = RATIO_W + GAP_W;

   localparam logic [SINGLE_W-1:0]     SINGLE_MAX = '1;
   localparam logic [GAP_W-1:0]        GAP_MAX    = '1;
   localparam logic signed [ACC_W-1:0] ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [PCT_W-1:0]        PCT_SCALE  = 7'd100;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_STEP_GAIN   = 3'd0,
      REG_GAP_PENALTY = 3'd1,
      REG_DROP_LIMIT  = 3'd2,
      REG_SCORE_LOW   = 3'd3,
      REG_SCORE_HIGH  = 3'd4,
      REG_RATIO_MID   = 3'd5,
      REG_RATIO_HIGH  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]         step_gain;
      logic [GAIN_W-1:0]         gap_penalty;
      logic signed [SCORE_W-1:0] drop_limit;
      logic signed [SCORE_W-1:0] score_low;
      logic signed [SCORE_W-1:0] score_high;
      logic [RATIO_W-1:0]        ratio_mid_band;
      logic [RATIO_W-1:0]        ratio_high_band;
   } cfg_type;

   typedef struct packed {
      logic                      first;
      logic                      last;
      logic signed [STEP_W-1:0]  step;
      logic signed [DIFF_W-1:0]  max_gap;
      logic signed [SCORE_W-1:0] overlap_score;
   } step_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]   deepest_drop;
      logic [SINGLE_W-1:0]       single_count;
      logic [GAP_W-1:0]          long_gap_total;
      logic signed [SCORE_W-1:0] overlap_score;
   } stats_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > $signed({{2{ACC_MAX[ACC_W-1]}}, ACC_MAX})) begin
         r = ACC_MAX;
      end else if (v < $signed({{2{ACC_MIN[ACC_W-1]}}, ACC_MIN})) begin
         r = ACC_MIN;
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/oaqf_if.sv =====
// ---------------------------------------------------------------------------
// Overlap alignment quality filter channel interfaces
// Valid/ready channels for aligned site pairs and filter results.
// ---------------------------------------------------------------------------
interface oaqf_req_if;
   import oaqf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SITE_W-1:0]         site_left;
   logic [SITE_W-1:0]         site_right;
   logic signed [SCORE_W-1:0] overlap_score;
   logic                      last_pair;

   modport source (output valid, site_left, site_right, overlap_score, last_pair,
                   input ready);
   modport sink   (input valid, site_left, site_right, overlap_score, last_pair,
                   output ready);
endinterface

interface oaqf_rsp_if;
   import oaqf_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    accept;
   logic signed [ACC_W-1:0] worst_drop;
   logic [SINGLE_W-1:0]     single_matches;
   logic [GAP_W-1:0]        gap_sum;

   modport source (output valid, accept, worst_drop, single_matches, gap_sum,
                   input ready);
   modport sink   (input valid, accept, worst_drop, single_matches, gap_sum,
                   output ready);
endinterface

// ===== hdl/overlap_alignment_quality_filter_unit.sv =====
// ---------------------------------------------------------------------------
// Overlap alignment quality filter unit
// Streams aligned site pairs of a map overlap and reports accept/reject with
// drop, single-match and gap statistics on the last pair.
//
//   channel  dir   protocol     transfer
//   req_if   in    valid/ready  one aligned site pair
//   rsp_if   out   valid/ready  one result per overlap (last pair only)
//   csr      in    APB          register write/read, pready always high
//
// One pair per cycle sustained; a result becomes valid after its last pair
// passes the step, statistics and output registers behind the input reg.
// The accumulator loop is combinational between its state registers: add,
// peak compare, drop compare. Synchronous active-high reset clears state;
// no memory, no clearing pass. While a result waits, pairs keep flowing until
// a last pair reaches the accumulator; that pair and the pairs behind it then stall.
// ---------------------------------------------------------------------------
`include "overlap_alignment_quality_filter_unit_defines.svh"

module overlap_alignment_quality_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   oaqf_req_if.sink                          req_if,
   oaqf_rsp_if.source                        rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [oaqf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [oaqf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [oaqf_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import oaqf_pkg::*;

   // configuration
   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_idx;
   logic          csr_write;

   assign pready    = 1'b1;
   assign reg_idx   = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_STEP_GAIN:   cfg_in.step_gain       = pwdata[GAIN_W-1:0];
            REG_GAP_PENALTY: cfg_in.gap_penalty     = pwdata[GAIN_W-1:0];
            REG_DROP_LIMIT:  cfg_in.drop_limit      = pwdata[SCORE_W-1:0];
            REG_SCORE_LOW:   cfg_in.score_low       = pwdata[SCORE_W-1:0];
            REG_SCORE_HIGH:  cfg_in.score_high      = pwdata[SCORE_W-1:0];
            REG_RATIO_MID:   cfg_in.ratio_mid_band  = pwdata[RATIO_W-1:0];
            REG_RATIO_HIGH:  cfg_in.ratio_high_band = pwdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_STEP_GAIN:   prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.step_gain};
         REG_GAP_PENALTY: prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.gap_penalty};
         REG_DROP_LIMIT:  prdata = {{(CSR_DATA_W-SCORE_W){cfg_ff.drop_limit[SCORE_W-1]}},
                                    cfg_ff.drop_limit};
         REG_SCORE_LOW:   prdata = {{(CSR_DATA_W-SCORE_W){cfg_ff.score_low[SCORE_W-1]}},
                                    cfg_ff.score_low};
         REG_SCORE_HIGH:  prdata = {{(CSR_DATA_W-SCORE_W){cfg_ff.score_high[SCORE_W-1]}},
                                    cfg_ff.score_high};
         REG_RATIO_MID:   prdata = {{(CSR_DATA_W-RATIO_W){1'b0}}, cfg_ff.ratio_mid_band};
         REG_RATIO_HIGH:  prdata = {{(CSR_DATA_W-RATIO_W){1'b0}}, cfg_ff.ratio_high_band};
         default:         prdata = '0;
      endcase
   end

   // stage flow control
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, rsp_valid_ff, rsp_valid_in;
   logic out_free, s3_free, s2_free, s1_free;
   logic s3_move, s2_move, s1_move, req_take;

   step_type  step_ff, step_in;
   stats_type stats_ff, stats_in;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign s3_move  = v3_ff && out_free;
   assign s3_free  = !v3_ff || out_free;
   assign s2_move  = v2_ff && (!step_ff.last || s3_free);
   assign s2_free  = !v2_ff || !step_ff.last || s3_free;
   assign s1_move  = v1_ff && s2_free;
   assign s1_free  = !v1_ff || s2_free;
   assign req_take = req_if.valid && s1_free;

   assign req_if.ready = s1_free;

   assign v1_in        = req_take || (v1_ff && !s1_move);
   assign v2_in        = s1_move || (v2_ff && !s2_move);
   assign v3_in        = (s2_move && step_ff.last) || (v3_ff && !s3_move);
   assign rsp_valid_in = s3_move || (rsp_valid_ff && !rsp_if.ready);

   // input register
   logic [SITE_W-1:0]         left_ff, right_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic                      last_ff;
   logic [SITE_W-1:0]         prev_left_ff, prev_left_in, prev_right_ff, prev_right_in;
   logic                      first_pending_ff, first_pending_in;

   logic signed [DIFF_W-1:0]   gap_left, gap_right;
   logic signed [GSUM_W-1:0]   gap_extra;
   logic signed [STEP_W-1:0]   penalty_prod;

   always_comb begin
      gap_left     = $signed({1'b0, left_ff}) - $signed({1'b0, prev_left_ff});
      gap_right    = $signed({1'b0, right_ff}) - $signed({1'b0, prev_right_ff});
      gap_extra    = {{2{gap_left[DIFF_W-1]}}, gap_left}
                     + {{2{gap_right[DIFF_W-1]}}, gap_right} - GSUM_W'(2);
      penalty_prod = $signed({1'b0, cfg_ff.gap_penalty}) * gap_extra;

      step_in               = step_ff;
      step_in.first         = first_pending_ff;
      step_in.last          = last_ff;
      step_in.step          = $signed({{(STEP_W-GAIN_W){1'b0}}, cfg_ff.step_gain})
                              - penalty_prod;
      step_in.max_gap       = (gap_left > gap_right) ? gap_left : gap_right;
      step_in.overlap_score = score_ff;

      prev_left_in     = prev_left_ff;
      prev_right_in    = prev_right_ff;
      first_pending_in = first_pending_ff;
      if (s1_move) begin
         prev_left_in     = left_ff;
         prev_right_in    = right_ff;
         first_pending_in = last_ff;
      end
   end

   oaqf_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step_move (s2_move),
      .step_item (step_ff),
      .stats     (stats_in)
   );

   logic accept_in;

   oaqf_decide u_decide (
      .cfg    (cfg_ff),
      .stats  (stats_ff),
      .accept (accept_in)
   );

   logic                    accept_ff;
   logic signed [ACC_W-1:0] drop_ff;
   logic [SINGLE_W-1:0]     single_ff;
   logic [GAP_W-1:0]        gap_sum_ff;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.accept         = accept_ff;
   assign rsp_if.worst_drop     = drop_ff;
   assign rsp_if.single_matches = single_ff;
   assign rsp_if.gap_sum        = gap_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '{step_gain:       8'd9,
                               gap_penalty:     8'd12,
                               drop_limit:      -16'sd30,
                               score_low:       16'sd80,
                               score_high:      16'sd100,
                               ratio_mid_band:  16'd150,
                               ratio_high_band: 16'd188};
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         prev_left_ff     <= '0;
         prev_right_ff    <= '0;
         first_pending_ff <= 1'b1;
      end else begin
         cfg_ff           <= cfg_in;
         v1_ff            <= v1_in;
         v2_ff            <= v2_in;
         v3_ff            <= v3_in;
         rsp_valid_ff     <= rsp_valid_in;
         prev_left_ff     <= prev_left_in;
         prev_right_ff    <= prev_right_in;
         first_pending_ff <= first_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         left_ff  <= req_if.site_left;
         right_ff <= req_if.site_right;
         score_ff <= req_if.overlap_score;
         last_ff  <= req_if.last_pair;
      end
      if (s1_move) begin
         step_ff <= step_in;
      end
      if (s2_move && step_ff.last) begin
         stats_ff <= stats_in;
      end
      if (s3_move) begin
         accept_ff  <= accept_in;
         drop_ff    <= stats_ff.deepest_drop;
         single_ff  <= stats_ff.single_count;
         gap_sum_ff <= stats_ff.long_gap_total;
      end
   end

   `OAQF_ASSERT_IMPLIES(a_rsp_drop_sign, rsp_valid_ff,
                        drop_ff[ACC_W-1] || drop_ff == '0, "positive worst drop on result")
   `OAQF_ASSERT_NEXT(a_stats_to_output, v3_ff && out_free, rsp_valid_ff,
                     "statistics did not reach output register")
   `OAQF_ASSERT_NEXT(a_stats_hold, v3_ff && !out_free, v3_ff && $stable(stats_ff),
                     "pending statistics overwritten")

endmodule

// ===== hdl/oaqf_accum.sv =====
// ---------------------------------------------------------------------------
// Overlap alignment quality filter: score accumulator
// Running score, peak, deepest drop, single-match count and gap sum.
// ---------------------------------------------------------------------------
`include "overlap_alignment_quality_filter_unit_defines.svh"

module oaqf_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_move,
   input  oaqf_pkg::step_type   step_item,
   output oaqf_pkg::stats_type  stats
);
   import oaqf_pkg::*;

   logic signed [ACC_W-1:0] score_ff, score_in;
   logic signed [ACC_W-1:0] peak_ff, peak_in;
   logic signed [ACC_W-1:0] deep_ff, deep_in;
   logic [SINGLE_W-1:0]     single_ff, single_in;
   logic [GAP_W-1:0]        long_ff, long_in;

   logic signed [ACC_W-1:0] new_score, new_peak, new_deep, drop;
   logic [SINGLE_W-1:0]     new_single;
   logic [GAP_W-1:0]        new_long;
   logic [GAP_W:0]          long_sum;

   always_comb begin
      new_score = sat_acc({{2{score_ff[ACC_W-1]}}, score_ff}
                          + {{(ACC_W+2-STEP_W){step_item.step[STEP_W-1]}}, step_item.step});
      new_peak  = (new_score > peak_ff) ? new_score : peak_ff;
      drop      = sat_acc({{2{new_score[ACC_W-1]}}, new_score}
                          - {{2{new_peak[ACC_W-1]}}, new_peak});
      new_deep  = (drop < deep_ff) ? drop : deep_ff;
      long_sum  = {1'b0, long_ff}
                  + {{(GAP_W+1-DIFF_W){1'b0}}, step_item.max_gap[DIFF_W-1:0]};
      new_single = single_ff;
      new_long   = long_ff;
      if (step_item.max_gap == DIFF_W'(1)) begin
         if (single_ff != SINGLE_MAX) begin
            new_single = single_ff + 1'b1;
         end
      end else if (step_item.max_gap > 0) begin
         new_long = long_sum[GAP_W] ? GAP_MAX : long_sum[GAP_W-1:0];
      end
      if (step_item.first) begin
         new_score  = score_ff;
         new_peak   = peak_ff;
         new_deep   = deep_ff;
         new_single = single_ff;
         new_long   = long_ff;
      end
   end

   assign stats = '{deepest_drop:   new_deep,
                    single_count:   new_single,
                    long_gap_total: new_long,
                    overlap_score:  step_item.overlap_score};

   always_comb begin
      score_in  = score_ff;
      peak_in   = peak_ff;
      deep_in   = deep_ff;
      single_in = single_ff;
      long_in   = long_ff;
      if (step_move) begin
         if (step_item.last) begin
            score_in  = '0;
            peak_in   = '0;
            deep_in   = '0;
            single_in = '0;
            long_in   = '0;
         end else begin
            score_in  = new_score;
            peak_in   = new_peak;
            deep_in   = new_deep;
            single_in = new_single;
            long_in   = new_long;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff  <= '0;
         peak_ff   <= '0;
         deep_ff   <= '0;
         single_ff <= '0;
         long_ff   <= '0;
      end else begin
         score_ff  <= score_in;
         peak_ff   <= peak_in;
         deep_ff   <= deep_in;
         single_ff <= single_in;
         long_ff   <= long_in;
      end
   end

   `OAQF_ASSERT_HOLDS(a_peak_above_score, score_ff <= peak_ff, "running score above peak")
   `OAQF_ASSERT_HOLDS(a_drop_nonpositive, deep_ff <= 0, "deepest drop positive")
   `OAQF_ASSERT_NEXT(a_clear_after_last, step_move && step_item.last, score_ff == 0 && peak_ff == 0 && deep_ff == 0 && single_ff == 0 && long_ff == 0, "state not cleared after last pair")

endmodule

// ===== hdl/oaqf_decide.sv =====
// ---------------------------------------------------------------------------
// Overlap alignment quality filter: accept decision
// Drop limit, score bound and banded match-ratio test on final statistics.
// ---------------------------------------------------------------------------
module oaqf_decide (
   input  oaqf_pkg::cfg_type    cfg,
   input  oaqf_pkg::stats_type  stats,
   output logic                 accept
);
   import oaqf_pkg::*;

   logic                    drop_fail;
   logic                    score_fail;
   logic [RATIO_W-1:0]      thr;
   logic [LHS_W-1:0]        lhs;
   logic [RHS_W-1:0]        rhs;
   logic                    ratio_ok;
   logic signed [ACC_W-1:0] drop_limit_ext;

   always_comb begin
      drop_limit_ext = {{(ACC_W-SCORE_W){cfg.drop_limit[SCORE_W-1]}}, cfg.drop_limit};
      drop_fail  = stats.deepest_drop < drop_limit_ext;
      score_fail = stats.overlap_score < cfg.score_low;
      thr        = (stats.overlap_score < cfg.score_high) ? cfg.ratio_mid_band
                                                          : cfg.ratio_high_band;
      lhs        = stats.single_count * PCT_SCALE;
      rhs        = thr * stats.long_gap_total;
      ratio_ok   = (stats.long_gap_total == '0)
                   || ({{(RHS_W-LHS_W){1'b0}}, lhs} >= rhs);
      accept     = !drop_fail && !score_fail && ratio_ok;
   end

endmodule
